// ===== rtl/sacl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int ADDR_W     = 32;
   localparam int WAY_OUT_W  = 3;
   localparam int COUNT_W    = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [3:0] OFFSET_BITS_RST = 4'd5;
   localparam logic [3:0] LINES_LOG2_RST  = 4'd5;
   localparam logic [1:0] WAYS_LOG2_RST   = 2'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_LINES_LOG2  = 2'd1,
      CSR_WAYS_LOG2   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [3:0] offset_bits;
      logic [3:0] lines_log2;
      logic [1:0] ways_log2;
   } cfg_type;

   typedef struct packed {
      logic clear_restart;
      logic clear_write;
      logic lookup;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } ctrl_status_type;

endpackage
`default_nettype wire

// ===== rtl/sacl_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_stream_if
// Valid/ready channels: access requests and lookup responses.
// ----------------------------------------------------------------------------
interface sacl_req_if;
   import sacl_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface sacl_rsp_if;
   import sacl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [WAY_OUT_W-1:0] way_used;
   logic [COUNT_W-1:0]   miss_total;

   modport source (output valid, output hit, output way_used, output miss_total, input ready);
   modport sink   (input valid, input hit, input way_used, input miss_total, output ready);
endinterface
`default_nettype wire

// ===== rtl/sacl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/sacl_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_csr
// APB-style configuration registers; any listed write requests reinit.
// ----------------------------------------------------------------------------
module sacl_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sacl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sacl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sacl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output sacl_pkg::cfg_type               cfg,
   output logic                            cfg_touch
);
   import sacl_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type idx;
   logic          wr;

   assign idx        = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in    = cfg_ff;
      cfg_touch = 1'b0;
      if (wr) begin
         case (idx)
            CSR_OFFSET_BITS: begin
               cfg_in.offset_bits = csr_pwdata[3:0];
               cfg_touch          = 1'b1;
            end
            CSR_LINES_LOG2: begin
               cfg_in.lines_log2 = csr_pwdata[3:0];
               cfg_touch         = 1'b1;
            end
            CSR_WAYS_LOG2: begin
               cfg_in.ways_log2 = csr_pwdata[1:0];
               cfg_touch        = 1'b1;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_OFFSET_BITS: csr_prdata = CSR_DATA_W'(cfg_ff.offset_bits);
         CSR_LINES_LOG2:  csr_prdata = CSR_DATA_W'(cfg_ff.lines_log2);
         CSR_WAYS_LOG2:   csr_prdata = CSR_DATA_W'(cfg_ff.ways_log2);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_bits <= OFFSET_BITS_RST;
         cfg_ff.lines_log2  <= LINES_LOG2_RST;
         cfg_ff.ways_log2   <= WAYS_LOG2_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/sacl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: clearing pass, set read, compare and write-back.
// ----------------------------------------------------------------------------
module sacl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cfg_touch,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  sacl_pkg::ctrl_status_type status,
   output sacl_pkg::ctrl_cmd_type    cmd
);
   import sacl_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_CMP   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.lookup = 1'b1;
               state_in   = ST_CMP;
            end
         end
         ST_CMP: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      if (cfg_touch) begin
         cmd               = '0;
         cmd.clear_restart = 1'b1;
         req_ready         = 1'b0;
         state_in          = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/sacl_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_dpath
// Address decode, set RAM, tag compare, age update, miss count, result reg.
// ----------------------------------------------------------------------------
module sacl_dpath #(
   parameter int MAX_LINES = 1024,
   parameter int MAX_WAYS  = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sacl_pkg::cfg_type              cfg,
   input  sacl_pkg::ctrl_cmd_type         cmd,
   output sacl_pkg::ctrl_status_type      status,
   input  logic [sacl_pkg::ADDR_W-1:0]    req_address,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_hit,
   output logic [sacl_pkg::WAY_OUT_W-1:0] rsp_way_used,
   output logic [sacl_pkg::COUNT_W-1:0]   rsp_miss_total
);
   import sacl_pkg::*;

   localparam int LINES_LOG2_MAX = $clog2(MAX_LINES + 1) - 1;
   localparam int WAYS_LOG2_MAX  = $clog2(MAX_WAYS + 1) - 1;
   localparam int LANE_LOG2      = (WAYS_LOG2_MAX < LINES_LOG2_MAX) ?
                                   WAYS_LOG2_MAX : LINES_LOG2_MAX;
   localparam int LANES          = 1 << LANE_LOG2;
   localparam int LANE_W         = (LANE_LOG2 > 0) ? LANE_LOG2 : 1;
   localparam int ROWS           = 1 << (LINES_LOG2_MAX - LANE_LOG2);
   localparam int ROW_W          = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int AGE_W          = $clog2(LANES + 1);
   localparam int ENTRY_W        = 1 + ADDR_W + AGE_W;
   localparam int ROW_BITS       = LANES * ENTRY_W;
   localparam int LANE_MASK      = LANES - 1;

   // effective geometry
   logic [4:0]        lb;
   logic [1:0]        wb_lines, wb;
   logic [LANE_W-1:0] wmask;
   logic [AGE_W-1:0]  ways_age;

   // decode
   logic [ADDR_W-1:0] shifted, lmask, idx, tag_hi, tag_st;
   logic [ROW_W-1:0]  rd_row;
   logic [LANE_W-1:0] base_lane;

   logic [ADDR_W-1:0] tag_ff;
   logic [LANE_W-1:0] base_ff;
   logic [ROW_W-1:0]  row_ff;

   logic [ROW_W-1:0]   clr_ff, clr_in;
   logic [COUNT_W-1:0] miss_ff, miss_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_hit_ff;
   logic [WAY_OUT_W-1:0] out_way_ff;
   logic [COUNT_W-1:0] out_total_ff;

   logic [ROW_BITS-1:0] rd_data, wr_data, cmp_row, clr_row;
   logic [ROW_W-1:0]    wr_addr;
   logic                wr_en;

   logic              lane_v   [LANES];
   logic [ADDR_W-1:0] lane_t   [LANES];
   logic [AGE_W-1:0]  lane_a   [LANES];
   logic [LANES-1:0]  in_set, match, oldest;
   logic [LANE_W-1:0] hit_lane, vic_lane, sel_lane, way_off;
   logic [AGE_W-1:0]  mine;
   logic              hit;
   logic [31:0]       way_ext;

   always_comb begin
      lb = ({1'b0, cfg.lines_log2} > 5'(LINES_LOG2_MAX)) ? 5'(LINES_LOG2_MAX) :
           {1'b0, cfg.lines_log2};
      wb_lines = ({3'b000, cfg.ways_log2} > lb) ? lb[1:0] : cfg.ways_log2;
      wb = ({1'b0, wb_lines} > 3'(WAYS_LOG2_MAX)) ? 2'(WAYS_LOG2_MAX) : wb_lines;
      wmask    = LANE_W'((32'd1 << wb) - 32'd1);
      ways_age = AGE_W'(32'd1 << wb);
   end

   always_comb begin
      shifted   = req_address >> cfg.offset_bits;
      lmask     = (32'd1 << lb) - 32'd1;
      idx       = shifted & lmask;
      tag_hi    = req_address >> (6'(lb) + 6'(cfg.offset_bits));
      tag_st    = (tag_hi << wb) | (idx & 32'(wmask));
      rd_row    = ROW_W'(idx >> LANE_LOG2);
      base_lane = LANE_W'(idx & 32'(LANE_MASK)) & ~wmask;
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         tag_ff  <= tag_st;
         base_ff <= base_lane;
         row_ff  <= rd_row;
      end
   end

   // set compare and LRU update
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         lane_v[j] = rd_data[j*ENTRY_W + AGE_W + ADDR_W];
         lane_t[j] = rd_data[j*ENTRY_W + AGE_W +: ADDR_W];
         lane_a[j] = rd_data[j*ENTRY_W +: AGE_W];
         in_set[j] = ((LANE_W'(j) & ~wmask) == base_ff);
         match[j]  = in_set[j] & lane_v[j] & (lane_t[j] == tag_ff);
         oldest[j] = in_set[j] & (lane_a[j] == ways_age);
      end
      hit      = |match;
      hit_lane = '0;
      vic_lane = '0;
      for (int j = LANES - 1; j >= 0; j--) begin
         if (match[j]) begin
            hit_lane = LANE_W'(j);
         end
         if (oldest[j]) begin
            vic_lane = LANE_W'(j);
         end
      end
      mine     = lane_a[hit_lane];
      sel_lane = hit ? hit_lane : vic_lane;
      way_off  = sel_lane & wmask;
      way_ext  = 32'(way_off);
   end

   always_comb begin
      cmp_row = rd_data;
      clr_row = '0;
      for (int j = 0; j < LANES; j++) begin
         clr_row[j*ENTRY_W +: AGE_W] = AGE_W'(32'(LANE_W'(j) & wmask) + 32'd1);
         if (in_set[j]) begin
            if (LANE_W'(j) == sel_lane) begin
               cmp_row[j*ENTRY_W +: AGE_W] = AGE_W'(1);
               if (!hit) begin
                  cmp_row[j*ENTRY_W + AGE_W + ADDR_W] = 1'b1;
                  cmp_row[j*ENTRY_W + AGE_W +: ADDR_W] = tag_ff;
               end
            end else if (!hit || (lane_a[j] < mine)) begin
               cmp_row[j*ENTRY_W +: AGE_W] = lane_a[j] + AGE_W'(1);
            end
         end
      end
   end

   assign wr_en   = cmd.clear_write | cmd.commit;
   assign wr_addr = cmd.clear_write ? clr_ff : row_ff;
   assign wr_data = cmd.clear_write ? clr_row : cmp_row;

   sacl_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.lookup),
      .rd_addr (rd_row),
      .rd_data (rd_data)
   );

   always_comb begin
      clr_in = clr_ff;
      if (cmd.clear_restart) begin
         clr_in = '0;
      end else if (cmd.clear_write) begin
         clr_in = clr_ff + ROW_W'(1);
      end
      miss_in = miss_ff;
      if (cmd.clear_restart) begin
         miss_in = '0;
      end else if (cmd.commit && !hit) begin
         miss_in = miss_ff + COUNT_W'(1);
      end
      out_valid_in = out_valid_ff;
      if (cmd.commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         miss_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         miss_ff      <= miss_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_hit_ff   <= hit;
         out_way_ff   <= way_ext[WAY_OUT_W-1:0];
         out_total_ff <= miss_in;
      end
   end

   assign status.clear_last = (clr_ff == ROW_W'(ROWS - 1));
   assign status.out_free   = ~out_valid_ff | rsp_ready;

   assign rsp_valid      = out_valid_ff;
   assign rsp_hit        = out_hit_ff;
   assign rsp_way_used   = out_way_ff;
   assign rsp_miss_total = out_total_ff;

endmodule
`default_nettype wire

// ===== rtl/set_assoc_cache_lru_tags_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags_top
// Tag store of a set-associative cache with true LRU (age rank) replacement.
//
//   channel   dir   handshake          payload
//   req_bus   in    valid/ready        address
//   rsp_bus   out   valid/ready        hit, way_used, miss_total
//   csr_*     in    APB write/read     offset_bits, lines_log2, ways_log2
//
// Each access is one registered read of the set's RAM row, then compare, age
// update and row write-back; the next request is taken only after write-back.
// After reset and after each config write a clearing pass writes every RAM
// row, MAX_LINES / min(MAX_WAYS, MAX_LINES) rows (128 rows at the defaults),
// with no request taken. A result waits in an output register; the compare
// cycle stalls only while that register is still full.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tags_top #(
   parameter int MAX_LINES = 1024,
   parameter int MAX_WAYS  = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   sacl_req_if.sink                        req_bus,
   sacl_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sacl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sacl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sacl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import sacl_pkg::*;

   cfg_type         cfg;
   logic            cfg_touch;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   sacl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_touch   (cfg_touch)
   );

   sacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_touch (cfg_touch),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sacl_dpath #(
      .MAX_LINES (MAX_LINES),
      .MAX_WAYS  (MAX_WAYS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .req_address    (req_bus.address),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_hit        (rsp_bus.hit),
      .rsp_way_used   (rsp_bus.way_used),
      .rsp_miss_total (rsp_bus.miss_total)
   );

endmodule
`default_nettype wire
